// File: hdl/lkv_pkg.sv
// Package for the LRU key-value cache: field widths, register map,
// control struct and state type. Depends on nothing.
package lkv_pkg;

	localparam int DEF_ENTRIES = 16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 31;
	localparam int RD_W = 32;
	localparam int CAP_W = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [RD_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic lookup;
		logic update;
		logic touch;
		logic write_hit;
		logic insert;
		logic evict;
	} ctl_t;

endpackage

// File: hdl/lkv_if.sv
// Request and response channel interfaces for the LRU key-value cache.
// Depends on lkv_pkg.
interface lkv_req_if;
	logic valid;
	logic ready;
	logic op;
	logic signed [lkv_pkg::KEY_W-1:0] key;
	logic [lkv_pkg::VAL_W-1:0] value;
	modport source (output valid, op, key, value, input ready);
	modport sink (input valid, op, key, value, output ready);
endinterface

interface lkv_rsp_if;
	logic valid;
	logic ready;
	logic found;
	logic signed [lkv_pkg::RD_W-1:0] read_value;
	modport source (output valid, found, read_value, input ready);
	modport sink (input valid, found, read_value, output ready);
endinterface

// File: hdl/lkv_cell.sv
// One cache cell: key, value, valid flag and recency rank of one entry.
// Passes the free-slot token to its neighbour. Depends on lkv_pkg.
module lkv_cell #(
	parameter int RANK_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lkv_pkg::ctl_t             ctl,
	input  logic [lkv_pkg::KEY_W-1:0] key,
	input  logic [lkv_pkg::VAL_W-1:0] value,
	input  logic [RANK_W-1:0]         hit_rank,
	input  logic [RANK_W-1:0]         keep,
	input  logic                      free_in,
	output logic                      free_out,
	output logic                      match,
	output logic                      valid,
	output logic [RANK_W-1:0]         rank,
	output logic [lkv_pkg::VAL_W-1:0] entry_value
);

	logic                      valid_q;
	logic                      match_q;
	logic [RANK_W-1:0]         rank_q;
	logic [lkv_pkg::KEY_W-1:0] key_q;
	logic [lkv_pkg::VAL_W-1:0] value_q;
	logic                      evicted;
	logic                      take;

	assign match       = valid_q && (key_q == key);
	assign evicted     = ctl.evict && valid_q && (rank_q >= keep);
	assign take        = (!valid_q || evicted) && !free_in;
	assign free_out    = free_in || !valid_q || evicted;
	assign valid       = valid_q;
	assign rank        = rank_q;
	assign entry_value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctl.lookup) begin
			match_q <= match;
		end else if (ctl.update) begin
			if (ctl.insert) begin
				if (take) begin
					valid_q <= 1'b1;
					rank_q  <= '0;
				end else if (evicted) begin
					valid_q <= 1'b0;
					rank_q  <= '0;
				end else if (valid_q) begin
					rank_q <= rank_q + RANK_W'(1);
				end
			end else if (ctl.touch) begin
				if (match_q) begin
					rank_q <= '0;
				end else if (valid_q && (rank_q < hit_rank)) begin
					rank_q <= rank_q + RANK_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update && ctl.insert && take) begin
			key_q   <= key;
			value_q <= value;
		end else if (ctl.update && ctl.write_hit && match_q) begin
			value_q <= value;
		end
	end

endmodule

// File: hdl/lkv_cell_row.sv
// Row of cache cells chained by the free-slot token, with the hit reduction.
// Depends on lkv_pkg and lkv_cell.
module lkv_cell_row #(
	parameter int ENTRIES = lkv_pkg::DEF_ENTRIES,
	parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lkv_pkg::ctl_t             ctl,
	input  logic [lkv_pkg::KEY_W-1:0] key,
	input  logic [lkv_pkg::VAL_W-1:0] value,
	input  logic [RANK_W-1:0]         hit_rank,
	input  logic [RANK_W-1:0]         keep,
	output logic                      found,
	output logic [RANK_W-1:0]         found_rank,
	output logic [lkv_pkg::VAL_W-1:0] found_value,
	output logic [ENTRIES-1:0]        match_vec,
	output logic [ENTRIES-1:0]        valid_vec
);

	logic [ENTRIES:0]          free_c;
	logic [RANK_W-1:0]         rank_a  [ENTRIES];
	logic [lkv_pkg::VAL_W-1:0] value_a [ENTRIES];

	assign free_c[0] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkv_cell #(
			.RANK_W(RANK_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key),
			.value      (value),
			.hit_rank   (hit_rank),
			.keep       (keep),
			.free_in    (free_c[g]),
			.free_out   (free_c[g+1]),
			.match      (match_vec[g]),
			.valid      (valid_vec[g]),
			.rank       (rank_a[g]),
			.entry_value(value_a[g])
		);
	end

	always_comb begin
		found_rank  = '0;
		found_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				found_rank  = found_rank | rank_a[i];
				found_value = found_value | value_a[i];
			end
		end
	end

	assign found = |match_vec;

endmodule

// File: hdl/lru_key_value_cache_top.sv
// Fully associative key-value cache with least-recently-used replacement.
// An accepted request is compared against every cell in the next cycle; the cells
// are then updated in ST_UPDATE once any earlier response has been taken, and the
// response is registered with that update. Only one request is in flight: a new
// one is accepted only in ST_IDLE. Reset leaves every entry invalid, the entry
// count at zero and capacity at 16; there is no clearing pass.
module lru_key_value_cache_top #(
	parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lkv_req_if.sink                     req,
	lkv_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkv_pkg::PADDR_W-1:0] paddr,
	input  logic [lkv_pkg::PDATA_W-1:0] pwdata,
	output logic [lkv_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	lkv_pkg::state_t           state_q;
	lkv_pkg::state_t           state_d;
	lkv_pkg::ctl_t             ctl;
	logic [lkv_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]          cap_eff;
	logic [CNT_W-1:0]          count_q;
	logic [RANK_W-1:0]         keep;
	logic                      advance;
	logic                      set_ok;

	logic                      op_s1;
	logic [lkv_pkg::KEY_W-1:0] key_s1;
	logic [lkv_pkg::VAL_W-1:0] value_s1;

	logic                      hit_q;
	logic [RANK_W-1:0]         hit_rank_q;
	logic [lkv_pkg::VAL_W-1:0] hit_value_q;

	logic                      row_found;
	logic [RANK_W-1:0]         row_rank;
	logic [lkv_pkg::VAL_W-1:0] row_value;
	logic [ENTRIES-1:0]        match_vec;
	logic [ENTRIES-1:0]        valid_vec;

	logic                      rsp_valid_q;
	logic                      found_q;
	logic [lkv_pkg::RD_W-1:0]  read_value_q;

	assign pready = 1'b1;
	assign prdata = lkv_pkg::PDATA_W'(capacity_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == lkv_pkg::REG_CAPACITY)) begin
			capacity_q <= pwdata[lkv_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		if (int'(capacity_q) > ENTRIES) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
	end

	assign keep    = RANK_W'(cap_eff - CNT_W'(1));
	assign advance = !rsp_valid_q || rsp.ready;
	assign set_ok  = (op_s1 == lkv_pkg::OP_SET) && (cap_eff != '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lkv_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = lkv_pkg::ST_LOOKUP;
				end
			end
			lkv_pkg::ST_LOOKUP: begin
				state_d = lkv_pkg::ST_UPDATE;
			end
			lkv_pkg::ST_UPDATE: begin
				if (advance) begin
					state_d = lkv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lkv_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready     = 1'b0;
		ctl.lookup    = 1'b0;
		ctl.update    = 1'b0;
		ctl.touch     = hit_q && ((op_s1 == lkv_pkg::OP_GET) || set_ok);
		ctl.write_hit = set_ok && hit_q;
		ctl.insert    = set_ok && !hit_q;
		ctl.evict     = set_ok && !hit_q && (count_q >= cap_eff);
		case (state_q)
			lkv_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			lkv_pkg::ST_LOOKUP: begin
				ctl.lookup = 1'b1;
			end
			lkv_pkg::ST_UPDATE: begin
				ctl.update = advance;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkv_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.update) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (ctl.update && ctl.insert) begin
				count_q <= ctl.evict ? cap_eff : count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1    <= req.op;
			key_s1   <= req.key;
			value_s1 <= req.value;
		end
		if (ctl.lookup) begin
			hit_q       <= row_found;
			hit_rank_q  <= row_rank;
			hit_value_q <= row_value;
		end
		if (ctl.update) begin
			found_q <= hit_q;
			if ((op_s1 == lkv_pkg::OP_GET) && hit_q) begin
				read_value_q <= {1'b0, hit_value_q};
			end else begin
				read_value_q <= lkv_pkg::MISS_VALUE;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = found_q;
	assign rsp.read_value = read_value_q;

	lkv_cell_row #(
		.ENTRIES(ENTRIES),
		.RANK_W (RANK_W)
	) u_row (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.key        (key_s1),
		.value      (value_s1),
		.hit_rank   (hit_rank_q),
		.keep       (keep),
		.found      (row_found),
		.found_rank (row_rank),
		.found_value(row_value),
		.match_vec  (match_vec),
		.valid_vec  (valid_vec)
	);

	// The entry count always equals the number of valid cells.
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("entry count differs from number of valid cells");

	// Keys are unique among valid cells, so at most one cell matches.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell matches the key");

	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == lkv_pkg::ST_LOOKUP))
		else $error("accepted request did not enter lookup");

	a_update_gives_response: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update |=> (rsp_valid_q && (state_q == lkv_pkg::ST_IDLE)))
		else $error("cell update did not register a response");

endmodule
